@@ sv/pls_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package pls_pkg;

  localparam int CAPACITY_DEF  = 16;
  localparam int CMD_W         = 3;
  localparam int VALUE_W       = 32;
  localparam int POSITION_W    = 5;
  localparam int STATUS_W      = 2;
  localparam int FOUND_INDEX_W = 4;
  localparam int ELEM_COUNT_W  = 5;

  localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_FIND   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]          command;
    logic signed [VALUE_W-1:0] value;
    logic [POSITION_W-1:0]     position;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic                     found;
    logic [FOUND_INDEX_W-1:0] found_index;
    logic [ELEM_COUNT_W-1:0]  element_count;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic                wr_in;
    logic                cap_up;
    logic                cap_dn;
    logic                cap_fd;
    logic                rd_up;
    logic                rd_dn;
    logic                rd_fd;
    logic                wr_shift;
    logic                wr_val;
    logic                idx_dec;
    logic                idx_inc;
    logic                cnt_inc;
    logic                cnt_dec;
    logic                cnt_clr;
    logic                res_go;
    logic [STATUS_W-1:0] res_status;
    logic                res_found;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic             full;
    logic             ins_ok;
    logic             rem_ok;
    logic             at_pos;
    logic             dn_last;
    logic             fd_end;
    logic             match;
  } sts_t;

endpackage

`default_nettype wire

@@ sv/pls_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pls_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  pls_pkg::sts_t      sts,
  output pls_pkg::ctl_t      ctl
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_UP_CHK = 3'd1;
  localparam logic [2:0] S_UP_WR  = 3'd2;
  localparam logic [2:0] S_DN_CHK = 3'd3;
  localparam logic [2:0] S_DN_WR  = 3'd4;
  localparam logic [2:0] S_FD_CHK = 3'd5;
  localparam logic [2:0] S_FD_CMP = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (sts.command)
            pls_pkg::CMD_APPEND: begin
              ctl.res_go = 1'b1;
              if (sts.full) begin
                ctl.res_status = pls_pkg::ST_FULL;
              end else begin
                ctl.res_status = pls_pkg::ST_OK;
                ctl.wr_in      = 1'b1;
                ctl.cnt_inc    = 1'b1;
              end
            end
            pls_pkg::CMD_INSERT: begin
              if (sts.full) begin
                ctl.res_go     = 1'b1;
                ctl.res_status = pls_pkg::ST_FULL;
              end else if (!sts.ins_ok) begin
                ctl.res_go     = 1'b1;
                ctl.res_status = pls_pkg::ST_RANGE;
              end else begin
                ctl.cap_up = 1'b1;
                state_nxt  = S_UP_CHK;
              end
            end
            pls_pkg::CMD_REMOVE: begin
              if (!sts.rem_ok) begin
                ctl.res_go     = 1'b1;
                ctl.res_status = pls_pkg::ST_RANGE;
              end else begin
                ctl.cap_dn = 1'b1;
                state_nxt  = S_DN_CHK;
              end
            end
            pls_pkg::CMD_FIND: begin
              ctl.cap_fd = 1'b1;
              state_nxt  = S_FD_CHK;
            end
            pls_pkg::CMD_CLEAR: begin
              ctl.cnt_clr    = 1'b1;
              ctl.res_go     = 1'b1;
              ctl.res_status = pls_pkg::ST_OK;
            end
            default: begin
              ctl.res_go     = 1'b1;
              ctl.res_status = pls_pkg::ST_OK;
            end
          endcase
        end
      end
      S_UP_CHK: begin
        if (sts.at_pos) begin
          ctl.wr_val     = 1'b1;
          ctl.cnt_inc    = 1'b1;
          ctl.res_go     = 1'b1;
          ctl.res_status = pls_pkg::ST_OK;
          state_nxt      = S_IDLE;
        end else begin
          ctl.rd_up = 1'b1;
          state_nxt = S_UP_WR;
        end
      end
      S_UP_WR: begin
        ctl.wr_shift = 1'b1;
        ctl.idx_dec  = 1'b1;
        state_nxt    = S_UP_CHK;
      end
      S_DN_CHK: begin
        if (sts.dn_last) begin
          ctl.cnt_dec    = 1'b1;
          ctl.res_go     = 1'b1;
          ctl.res_status = pls_pkg::ST_OK;
          state_nxt      = S_IDLE;
        end else begin
          ctl.rd_dn = 1'b1;
          state_nxt = S_DN_WR;
        end
      end
      S_DN_WR: begin
        ctl.wr_shift = 1'b1;
        ctl.idx_inc  = 1'b1;
        state_nxt    = S_DN_CHK;
      end
      S_FD_CHK: begin
        if (sts.fd_end) begin
          ctl.res_go     = 1'b1;
          ctl.res_status = pls_pkg::ST_OK;
          state_nxt      = S_IDLE;
        end else begin
          ctl.rd_fd = 1'b1;
          state_nxt = S_FD_CMP;
        end
      end
      S_FD_CMP: begin
        if (sts.match) begin
          ctl.res_go     = 1'b1;
          ctl.res_status = pls_pkg::ST_OK;
          ctl.res_found  = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          ctl.idx_inc = 1'b1;
          state_nxt   = S_FD_CHK;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

@@ sv/pls_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pls_datapath #(
  parameter int CAPACITY = pls_pkg::CAPACITY_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  pls_pkg::in_item_t       in_item,
  input  pls_pkg::ctl_t           ctl,
  output pls_pkg::sts_t           sts,
  output logic                    out_strobe,
  output pls_pkg::out_item_t      out_item
);

  localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int PW   = pls_pkg::POSITION_W;
  localparam int XW   = (CW > PW) ? CW : PW;
  localparam int VW   = pls_pkg::VALUE_W;
  localparam int FIW  = pls_pkg::FOUND_INDEX_W;
  localparam int ECW  = pls_pkg::ELEM_COUNT_W;

  logic [VW-1:0] mem [CAPACITY];

  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic [CW-1:0] idx_r;
  logic [CW-1:0] pos_r;
  logic [VW-1:0] val_r;
  logic [VW-1:0] rdata_r;

  logic [XW-1:0] pos_x;
  logic [XW-1:0] cnt_x;
  logic [CW-1:0] idx_up;
  logic [CW-1:0] idx_dn;

  logic          we;
  logic [AW-1:0] wa;
  logic [VW-1:0] wd;
  logic          re;
  logic [AW-1:0] ra;

  logic                       out_strobe_r;
  pls_pkg::out_item_t         out_item_r;

  assign pos_x  = XW'(in_item.position);
  assign cnt_x  = XW'(count_r);
  assign idx_up = idx_r + CW'(1);
  assign idx_dn = idx_r - CW'(1);

  always_comb begin
    sts.command = in_item.command;
    sts.full    = (count_r == CW'(CAPACITY));
    sts.ins_ok  = (pos_x <= cnt_x);
    sts.rem_ok  = (pos_x < cnt_x);
    sts.at_pos  = (idx_r == pos_r);
    sts.dn_last = (idx_up == count_r);
    sts.fd_end  = (idx_r == count_r);
    sts.match   = (rdata_r == val_r);
  end

  always_comb begin
    we = ctl.wr_in | ctl.wr_val | ctl.wr_shift;
    wa = idx_r[AW-1:0];
    wd = rdata_r;
    if (ctl.wr_in) begin
      wa = count_r[AW-1:0];
      wd = in_item.value;
    end else if (ctl.wr_val) begin
      wd = val_r;
    end
  end

  always_comb begin
    re = ctl.rd_up | ctl.rd_dn | ctl.rd_fd;
    ra = idx_r[AW-1:0];
    if (ctl.rd_up) begin
      ra = idx_dn[AW-1:0];
    end else if (ctl.rd_dn) begin
      ra = idx_up[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rdata_r <= mem[ra];
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (ctl.cnt_clr) begin
      count_nxt = '0;
    end else if (ctl.cnt_inc) begin
      count_nxt = count_r + CW'(1);
    end else if (ctl.cnt_dec) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cap_up | ctl.cap_dn | ctl.cap_fd) begin
      val_r <= in_item.value;
      pos_r <= CW'(in_item.position);
    end
    if (ctl.cap_up) begin
      idx_r <= count_r;
    end else if (ctl.cap_dn) begin
      idx_r <= CW'(in_item.position);
    end else if (ctl.cap_fd) begin
      idx_r <= '0;
    end else if (ctl.idx_dec) begin
      idx_r <= idx_dn;
    end else if (ctl.idx_inc) begin
      idx_r <= idx_up;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= ctl.res_go;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.res_go) begin
      out_item_r.status        <= ctl.res_status;
      out_item_r.found         <= ctl.res_found;
      out_item_r.found_index   <= ctl.res_found ? FIW'(idx_r) : '0;
      out_item_r.element_count <= ECW'(count_nxt);
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

`default_nettype wire

@@ sv/positional_list_store.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Ordered list of up to CAPACITY signed 32-bit values held in a simple dual-port
// RAM (one write, one registered read per cycle).
// Input: drive in_item and raise start; the transaction is taken at an edge
// where start is high and busy is low. Commands: append, insert, remove,
// find and clear.
// Output: every transaction yields one result on out_item, marked by
// out_strobe for exactly one cycle; the receiver cannot stall it.
// Append, clear, rejected and unknown commands finish in the accepting
// cycle with busy staying low, so these run back to back; out_strobe
// follows in the next cycle from the result register. Insert opens a gap
// at position, remove closes one, find scans from entry 0 to a hit or end.
// The loops move one entry at a time: a check state reads the RAM and a
// write state writes it back shifted (find compares instead); the
// controller holds busy until the result issues.
// Reset empties the list; the RAM contents are not cleared and need no
// clearing pass.

module positional_list_store #(
  parameter int CAPACITY = pls_pkg::CAPACITY_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  pls_pkg::in_item_t       in_item,
  output logic                    out_strobe,
  output pls_pkg::out_item_t      out_item
);

  pls_pkg::ctl_t ctl;
  pls_pkg::sts_t sts;

  pls_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .ctl   (ctl)
  );

  pls_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_item),
    .ctl        (ctl),
    .sts        (sts),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

`default_nettype wire
